>>> src/lcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the min-max linear contrast stretch core.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int PIX_W      = 16;
  localparam int NUM_W      = 24;
  localparam int QUOT_BITS  = 8;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic OP_GATHER  = 1'b0;
  localparam logic OP_STRETCH = 1'b1;

  localparam logic [1:0] CLS_FLAT = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_SAT  = 2'd2;
  localparam logic [1:0] CLS_DIV  = 2'd3;

  localparam logic [QUOT_BITS-1:0] QUOT_MAX = '1;

  typedef struct packed {
    logic                    opcode;
    logic signed [PIX_W-1:0] pixel_value;
    logic                    frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] stretched_value;
    logic                    flat_range;
  } out_item_t;

  typedef struct packed {
    logic [1:0]              cls;
    logic signed [PIX_W-1:0] pixel;
    logic [NUM_W-1:0]        num;
    logic [PIX_W-1:0]        den;
  } job_t;

endpackage

>>> src/lcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_front
// Accepts items, keeps the running min/max and turns stretch items into jobs.
// ----------------------------------------------------------------------------
module lcs_front import lcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     job_full,
  output logic     job_push,
  output job_t     job
);

  logic signed [PIX_W-1:0] min_r, min_nxt;
  logic signed [PIX_W-1:0] max_r, max_nxt;
  logic signed [PIX_W:0]   diff;
  logic signed [PIX_W:0]   rng;
  logic                    accept;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;
  assign job_push = accept && (in_item.opcode == OP_STRETCH);

  assign diff = {in_item.pixel_value[PIX_W-1], in_item.pixel_value} - {min_r[PIX_W-1], min_r};
  assign rng  = {max_r[PIX_W-1], max_r} - {min_r[PIX_W-1], min_r};

  always_comb begin
    job.pixel = in_item.pixel_value;
    job.den   = rng[PIX_W-1:0];
    job.num   = {diff[PIX_W-1:0], {(NUM_W-PIX_W){1'b0}}}
              - {{(NUM_W-PIX_W){1'b0}}, diff[PIX_W-1:0]};
    if (rng[PIX_W] || (rng == '0)) begin
      job.cls = CLS_FLAT;
    end else if (diff[PIX_W]) begin
      job.cls = CLS_ZERO;
    end else if (diff[PIX_W-1:0] >= rng[PIX_W-1:0]) begin
      job.cls = CLS_SAT;
    end else begin
      job.cls = CLS_DIV;
    end
  end

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (accept && (in_item.opcode == OP_GATHER)) begin
      if (in_item.frame_start) begin
        min_nxt = in_item.pixel_value;
        max_nxt = in_item.pixel_value;
      end else begin
        if (in_item.pixel_value < min_r) min_nxt = in_item.pixel_value;
        if (in_item.pixel_value > max_r) max_nxt = in_item.pixel_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

>>> src/lcs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_fifo
// Small job queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module lcs_fifo import lcs_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t            mem_r [DEPTH];
  job_t            rd_data_r;
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = rd_data_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  // head entry, with the write forwarded when it lands at the new head
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      rd_data_r <= push_data;
    end else begin
      rd_data_r <= mem_r[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> src/lcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_back
// Takes jobs off the queue, runs the restoring divider, holds the result.
// ----------------------------------------------------------------------------
module lcs_back import lcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_empty,
  input  job_t      job,
  output logic      job_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = (QUOT_BITS > 1) ? $clog2(QUOT_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_BITS - 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                 state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PIX_W-1:0]     rem_r, rem_nxt;
  logic [QUOT_BITS-1:0] low_r, low_nxt;
  logic [PIX_W-1:0]     den_r, den_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic                 can_load;
  logic [PIX_W:0]       trial;
  logic [PIX_W:0]       shifted;

  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign shifted   = {rem_r, low_r[QUOT_BITS-1]};
  assign trial     = shifted - {1'b0, den_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    den_nxt       = den_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    job_pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          case (job.cls)
            CLS_DIV: begin
              job_pop   = 1'b1;
              rem_nxt   = job.num[NUM_W-1 -: PIX_W];
              low_nxt   = job.num[QUOT_BITS-1:0];
              den_nxt   = job.den;
              cnt_nxt   = '0;
              state_nxt = ST_DIV;
            end
            CLS_FLAT: begin
              if (can_load) begin
                job_pop       = 1'b1;
                out_valid_nxt = 1'b1;
                out_item_nxt.stretched_value = job.pixel;
                out_item_nxt.flat_range      = 1'b1;
              end
            end
            CLS_ZERO: begin
              if (can_load) begin
                job_pop       = 1'b1;
                out_valid_nxt = 1'b1;
                out_item_nxt.stretched_value = '0;
                out_item_nxt.flat_range      = 1'b0;
              end
            end
            default: begin
              if (can_load) begin
                job_pop       = 1'b1;
                out_valid_nxt = 1'b1;
                out_item_nxt.stretched_value = {{(PIX_W-QUOT_BITS){1'b0}}, QUOT_MAX};
                out_item_nxt.flat_range      = 1'b0;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (cnt_r != CNT_LAST) begin
          cnt_nxt = cnt_r + 1'b1;
          if (!trial[PIX_W]) begin
            rem_nxt = trial[PIX_W-1:0];
            low_nxt = {low_r[QUOT_BITS-2:0], 1'b1};
          end else begin
            rem_nxt = shifted[PIX_W-1:0];
            low_nxt = {low_r[QUOT_BITS-2:0], 1'b0};
          end
        end else if (can_load) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.stretched_value = {{(PIX_W-QUOT_BITS){1'b0}}, low_r[QUOT_BITS-2:0],
                                          !trial[PIX_W]};
          out_item_nxt.flat_range      = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    low_r      <= low_nxt;
    den_r      <= den_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/linear_contrast_stretch_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_contrast_stretch_core
// Min-max linear contrast stretch: gather items track min/max, stretch items
// are scaled to 0..255 by a restoring divider or clamped, flat ranges pass
// through. Gather: one transfer per clock while the job queue has room.
// Stretch: clamped or flat pixels pass the job queue to the output register;
// divided pixels get 8 quotient bits, one per cycle (the last once the output
// register is free), and the back end takes no new job while it divides.
// Synchronous reset clears min/max to zero, empties the queue and the output.
// ----------------------------------------------------------------------------
module linear_contrast_stretch_core import lcs_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic job_full, job_empty, job_push, job_pop;
  job_t job_in, job_out;

  lcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  lcs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .full      (job_full),
    .empty     (job_empty)
  );

  lcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
